>>> sv/ddo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry package
// Shared constants, types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int unsigned CordicSteps = 24;
  localparam logic [31:0] MptReset    = 32'd599689;
  localparam logic [31:0] TptReset    = 32'd318146;
  localparam logic [31:0] CordicGain  = 32'd652032874;
  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

  localparam logic CfgMpt = 1'b0;
  localparam logic CfgTpt = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_COS0,
    ST_MOVE,
    ST_TURN,
    ST_COS1,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } cordic_ctl_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'h20000000;   5'd1: r = 32'h12E4051E;
        5'd2: r = 32'h09FB385B;   5'd3: r = 32'h051111D4;
        5'd4: r = 32'h028B0D43;   5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E;   5'd7: r = 32'h00517C55;
        5'd8: r = 32'h0028BE53;   5'd9: r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
        5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
        5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
        5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
        5'd30: r = 32'h00000001;  default: r = 32'h00000000;
      endcase
      return r;
    end
  endfunction

endpackage

>>> sv/ddo_serial_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial multiplier
// Unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddo_serial_mult (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] op_a,
  input  logic [31:0] op_b,
  output logic        done,
  output logic [79:0] prod
);

  logic [79:0] acc;
  logic [79:0] mcand;
  logic [31:0] mplier;
  logic [5:0]  cnt;
  logic        busy;

  // The multiplicand shifts left and the multiplier right, one bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        acc    <= '0;
        mcand  <= {32'd0, op_a};
        mplier <= op_b;
      end else if (busy) begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= {mcand[78:0], 1'b0};
        mplier <= {1'b0, mplier[31:1]};
        cnt    <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;

endmodule

>>> sv/ddo_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC sine and cosine
// Rotation-mode CORDIC, one step per cycle, quadrant folded at the end.
// ----------------------------------------------------------------------------
module ddo_cordic #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::CordicSteps
) (
  input  logic                clk,
  input  logic                rst,
  input  ddo_pkg::cordic_ctl_t ctl,
  input  logic [31:0]         ang,
  output logic                done,
  output logic signed [33:0]  cs,
  output logic signed [33:0]  sn
);

  logic signed [33:0] x, y;
  logic signed [32:0] z;
  logic [1:0]         quad;
  logic [5:0]         step;
  logic               busy;
  logic [31:0]        qa;
  logic signed [33:0] xs, ys, c0, s0;

  assign qa = ang + 32'h20000000;
  assign xs = x >>> step[4:0];
  assign ys = y >>> step[4:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        step <= '0;
        quad <= qa[31:30];
        z    <= 33'(signed'(ang - {qa[31:30], 30'd0}));
        x    <= 34'(ddo_pkg::CordicGain);
        y    <= '0;
      end else if (busy) begin
        if (!z[32]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - 33'(ddo_pkg::atan_entry(step[4:0]));
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + 33'(ddo_pkg::atan_entry(step[4:0]));
        end
        step <= step + 6'd1;
        if (step == 6'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (quad)
      2'd0: begin c0 = x;  s0 = y;  end
      2'd1: begin c0 = -y; s0 = x;  end
      2'd2: begin c0 = -x; s0 = -y; end
      default: begin c0 = y; s0 = -x; end
    endcase
    cs = (c0 > ddo_pkg::OneQ30) ? ddo_pkg::OneQ30 :
         (c0 < -ddo_pkg::OneQ30) ? -ddo_pkg::OneQ30 : c0;
    sn = (s0 > ddo_pkg::OneQ30) ? ddo_pkg::OneQ30 :
         (s0 < -ddo_pkg::OneQ30) ? -ddo_pkg::OneQ30 : s0;
  end

endmodule

>>> sv/diff_drive_odometry_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Differential-drive wheel odometry
// Integrates encoder counts into position, heading and yaw quaternion.
// ----------------------------------------------------------------------------
// Input beats carry absolute right and left encoder counts; output beats carry
// Q16.16 position, binary-angle heading and the half-angle sine and cosine.
// The first input beat after reset only latches the counts and yields nothing.
// Each later beat runs a sequence on one shared bit-serial multiplier and one
// iterative CORDIC unit: distance multiply, CORDIC, two direction multiplies,
// heading multiply, a second CORDIC and the load of the output register. The
// next beat is taken only after the output register has been loaded.
// One item is processed at a time; stall is low only in idle.
// The result sits in an output register until taken. While the receiver
// stalls, one further beat is accepted and worked through, and its result then
// waits inside the block, with input stalled, until the register frees.
// Reset restores both configuration registers and clears position and heading.
// Configuration writes are always accepted; index CfgMpt writes mpt, any other writes tpt.
// ----------------------------------------------------------------------------
module diff_drive_odometry_unit #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::CordicSteps
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] right_count,
  input  logic signed [31:0] left_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic        [31:0] heading,
  output logic signed [31:0] quat_z,
  output logic signed [31:0] quat_w,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic signed [47:0] AccMax = 48'sh7FFFFFFFFFFF;
  localparam logic signed [47:0] AccMin = 48'sh800000000000;

  ddo_pkg::state_t state, state_next;
  logic [31:0] mpt, tpt, last_r, last_l, angle;
  logic signed [47:0] acc_x, acc_y;
  logic primed, neg, phase;
  logic [47:0] travel;
  logic signed [33:0] cs_l, sn_l;
  logic [32:0] mag, mag_in;
  logic [31:0] dr, dl;
  logic [31:0] dr_r, dl_r;
  logic signed [32:0] sum;

  logic        m_start, m_done;
  logic [47:0] m_a;
  logic [31:0] m_b;
  logic [79:0] m_p;
  ddo_pkg::cordic_ctl_t c_ctl;
  logic        c_done;
  logic [31:0] c_ang;
  logic signed [33:0] c_cs, c_sn;
  logic        in_acc, out_acc, out_load;
  logic        mul_go, cor_go;

  ddo_serial_mult u_mult (
    .clk(clk), .rst(rst), .start(m_start), .op_a(m_a), .op_b(m_b),
    .done(m_done), .prod(m_p)
  );

  ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .ctl(c_ctl), .ang(c_ang), .done(c_done),
    .cs(c_cs), .sn(c_sn)
  );

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ddo_pkg::ST_IDLE);
  assign out_load  = (state == ddo_pkg::ST_OUT) && (!out_valid || !out_stall);

  assign dr     = right_count - last_r;
  assign dl     = left_count - last_l;
  assign sum    = 33'(signed'(dr)) + 33'(signed'(dl));
  assign mag_in = sum[32] ? 33'(-sum) : 33'(sum);

  // Magnitude of the step operand, signed cos or sin chosen by phase.
  logic signed [33:0] trig;
  logic signed [48:0] step_v, acc_new;
  logic signed [47:0] acc_sel, acc_sat;
  assign trig     = phase ? sn_l : cs_l;
  assign step_v   = (neg != trig[33]) ? -49'(m_p[77:30]) : 49'(m_p[77:30]);
  assign acc_sel  = phase ? acc_y : acc_x;
  assign acc_new  = 49'(acc_sel) + step_v;
  assign acc_sat  = (acc_new > 49'(AccMax)) ? AccMax :
                    (acc_new < 49'(AccMin)) ? AccMin : acc_new[47:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ddo_pkg::ST_IDLE: if (in_acc && primed) state_next = ddo_pkg::ST_DIST;
      ddo_pkg::ST_DIST: if (m_done) state_next = ddo_pkg::ST_COS0;
      ddo_pkg::ST_COS0: if (c_done) state_next = ddo_pkg::ST_MOVE;
      ddo_pkg::ST_MOVE: if (m_done && phase) state_next = ddo_pkg::ST_TURN;
      ddo_pkg::ST_TURN: if (m_done) state_next = ddo_pkg::ST_COS1;
      ddo_pkg::ST_COS1: if (c_done) state_next = ddo_pkg::ST_OUT;
      ddo_pkg::ST_OUT:  if (out_load) state_next = ddo_pkg::ST_IDLE;
      default:          state_next = ddo_pkg::ST_IDLE;
    endcase
  end

  // Start pulses for the shared units, issued on entry to each phase.
  always_comb begin
    mul_go = 1'b0;
    cor_go = 1'b0;
    m_a    = {15'd0, mag[32:1], 1'b0} >> 1;
    m_b    = mpt;
    c_ang  = angle;
    unique case (state)
      ddo_pkg::ST_IDLE: begin
        mul_go = in_acc && primed;
        m_a    = {15'd0, mag_in} >> 1;
      end
      ddo_pkg::ST_DIST: cor_go = m_done;
      ddo_pkg::ST_COS0: begin
        mul_go = c_done;
        m_a    = travel;
        m_b    = c_cs[33] ? 32'(-c_cs) : 32'(c_cs);
      end
      ddo_pkg::ST_MOVE: begin
        mul_go = m_done && !phase;
        m_a    = travel;
        m_b    = sn_l[33] ? 32'(-sn_l) : 32'(sn_l);
        if (m_done && phase) begin
          mul_go = 1'b1;
          m_a    = {16'd0, dr_r - dl_r};
          m_b    = tpt;
        end
      end
      ddo_pkg::ST_TURN: begin
        cor_go = m_done;
        c_ang  = (angle + m_p[31:0]) >> 1;
      end
      default: ;
    endcase
    m_start     = mul_go;
    c_ctl.start = cor_go;
    c_ctl.busy  = (state != ddo_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ddo_pkg::ST_IDLE;
      mpt       <= ddo_pkg::MptReset;
      tpt       <= ddo_pkg::TptReset;
      last_r    <= '0;
      last_l    <= '0;
      acc_x     <= '0;
      acc_y     <= '0;
      angle     <= '0;
      primed    <= 1'b0;
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ddo_pkg::CfgMpt) mpt <= cfg_data;
        else tpt <= cfg_data;
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_acc) out_valid <= 1'b0;
      unique case (state)
        ddo_pkg::ST_IDLE: begin
          if (in_acc) begin
            primed <= 1'b1;
            last_r <= right_count;
            last_l <= left_count;
            dr_r   <= dr;
            dl_r   <= dl;
            neg    <= sum[32];
            mag    <= mag_in;
            phase  <= 1'b0;
          end
        end
        ddo_pkg::ST_DIST: if (m_done) begin
          // Odd magnitudes add half a tick scale.
          logic [80:0] d;
          d = 81'(m_p) + (mag[0] ? 81'(mpt >> 1) : 81'd0);
          travel <= (d > 81'h7FFFFFFFFFFF) ? 48'h7FFFFFFFFFFF : d[47:0];
        end
        ddo_pkg::ST_COS0: if (c_done) begin
          cs_l <= c_cs;
          sn_l <= c_sn;
        end
        ddo_pkg::ST_MOVE: if (m_done) begin
          if (phase) acc_y <= acc_sat;
          else acc_x <= acc_sat;
          phase <= 1'b1;
        end
        ddo_pkg::ST_TURN: if (m_done) angle <= angle + m_p[31:0];
        ddo_pkg::ST_OUT: if (out_load) begin
          pos_x   <= acc_x[47:16];
          pos_y   <= acc_y[47:16];
          heading <= angle;
          quat_z  <= c_sn[31:0];
          quat_w  <= c_cs[31:0];
        end
        default: ;
      endcase
    end
  end

endmodule

>>> sv/ddo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry port checker
// Checks handshake and output properties seen at the top-level ports.
// ----------------------------------------------------------------------------
module ddo_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] quat_z,
  input logic signed [31:0] quat_w,
  input logic [31:0]        heading
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(heading))
    else $error("stalled output beat changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_quat_z: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (quat_z <= 32'sd1073741824) && (quat_z >= -32'sd1073741824))
    else $error("quat_z out of range");

  a_quat_w: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (quat_w <= 32'sd1073741824) && (quat_w >= -32'sd1073741824))
    else $error("quat_w out of range");

endmodule

bind diff_drive_odometry_unit ddo_checker u_ddo_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .quat_z(quat_z),
  .quat_w(quat_w), .heading(heading)
);

>>> tb/diff_drive_odometry_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry unit testbench
// Drives encoder count beats and configuration writes, and predicts every
// pose in fixed point. Each output beat is checked field by field against the
// oldest predicted pose, with random idling and stalls on both sides.
// ----------------------------------------------------------------------------
module diff_drive_odometry_unit_test;

  localparam int IdleLimit = 4000;
  localparam int Drain     = 250;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [31:0] h;
    logic signed [31:0] qz;
    logic signed [31:0] qw;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] right_count = '0;
  logic signed [31:0] left_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] pos_x, pos_y, quat_z, quat_w;
  logic [31:0] heading;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = ddo_pkg::CfgMpt;
  logic [31:0] cfg_data = '0;

  diff_drive_odometry_unit dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state and register copies.
  logic [31:0] mpt = ddo_pkg::MptReset;
  logic [31:0] tpt = ddo_pkg::TptReset;
  logic [31:0] last_r = '0, last_l = '0, ang = '0;
  longint acc_x = 0, acc_y = 0;
  bit primed = 0;
  pose_t expected_poses[$];

  bit calm = 0;
  int hold_req = 0;
  int hold_cnt = 0;
  int errors = 0;
  int idle_cycles = 0;

  longint atan_turns[32] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
    'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
    'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
    'h00000001, 'h00000000};

  function automatic longint clamp_unit(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  // Quadrant fold followed by rotation-mode CORDIC, Q1.30 results.
  function automatic void rotate_angle(input logic [31:0] a,
                                       output longint cs, output longint sn);
    logic [1:0] q;
    logic [31:0] rz;
    longint x, y, z, nx;
    q  = 2'((a + 32'h20000000) >> 30);
    rz = a - {q, 30'b0};
    z  = longint'(signed'(rz));
    x  = longint'(ddo_pkg::CordicGain);
    y  = 0;
    for (int i = 0; i < ddo_pkg::CordicSteps && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= atan_turns[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += atan_turns[i];
      end
      x = nx;
    end
    case (q)
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
    cs = clamp_unit(cs);
    sn = clamp_unit(sn);
  endfunction

  // Signed step along one axis, truncated toward zero.
  function automatic longint axis_step(longint unsigned d, bit neg, longint c);
    longint unsigned m, v;
    m = (c < 0) ? -c : c;
    v = (d >> 30) * m + (((d & 64'h3FFFFFFF) * m) >> 30);
    return (neg != (c < 0)) ? -longint'(v) : longint'(v);
  endfunction

  function automatic longint sat_acc(longint a, longint inc);
    longint r;
    r = a + inc;
    if (r > 64'sh7FFFFFFFFFFF) return 64'sh7FFFFFFFFFFF;
    if (r < -64'sh800000000000) return -64'sh800000000000;
    return r;
  endfunction

  function automatic void integrate_counts(logic [31:0] r, logic [31:0] l);
    logic signed [31:0] tr, tl;
    longint dr, dl, sum, cs, sn;
    longint unsigned mag, d;
    bit neg;
    pose_t p;
    if (!primed) begin
      last_r = r;
      last_l = l;
      primed = 1;
      return;
    end
    tr = r - last_r;
    tl = l - last_l;
    dr = tr;
    dl = tl;
    last_r = r;
    last_l = l;
    sum = dr + dl;
    neg = sum < 0;
    mag = neg ? -sum : sum;
    d = (mag >> 1) * longint'(mpt);
    if (mag[0]) d += longint'(mpt >> 1);
    if (d > 64'h7FFFFFFFFFFF) d = 64'h7FFFFFFFFFFF;
    rotate_angle(ang, cs, sn);
    acc_x = sat_acc(acc_x, axis_step(d, neg, cs));
    acc_y = sat_acc(acc_y, axis_step(d, neg, sn));
    ang = ang + 32'(dr - dl) * tpt;
    rotate_angle(ang >> 1, cs, sn);
    p.x  = 32'(acc_x >>> 16);
    p.y  = 32'(acc_y >>> 16);
    p.h  = ang;
    p.qz = 32'(sn);
    p.qw = 32'(cs);
    expected_poses.push_back(p);
  endfunction

  // Receiver: random stalls, quiet stretches and requested long hold-offs.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 37);
    end
  end

  always @(posedge clk) begin
    pose_t p;
    if (!rst && out_valid && !out_stall) begin
      if (expected_poses.size() == 0) begin
        $error("output beat with no pose expected");
        errors++;
      end else begin
        p = expected_poses.pop_front();
        if (pos_x !== p.x) begin
          $error("pos_x expected %0d got %0d", p.x, pos_x); errors++;
        end
        if (pos_y !== p.y) begin
          $error("pos_y expected %0d got %0d", p.y, pos_y); errors++;
        end
        if (heading !== p.h) begin
          $error("heading expected %h got %h", p.h, heading); errors++;
        end
        if (quat_z !== p.qz) begin
          $error("quat_z expected %0d got %0d", p.qz, quat_z); errors++;
        end
        if (quat_w !== p.qw) begin
          $error("quat_w expected %0d got %0d", p.qw, quat_w); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("diff_drive_odometry_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_counts(logic [31:0] r, logic [31:0] l);
    if (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    right_count <= r;
    left_count  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    integrate_counts(r, l);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == ddo_pkg::CfgMpt) mpt = v;
    else tpt = v;
  endtask

  task automatic test_directed();
    send_counts(32'h80000000, 32'h7FFFFFFF);   // first beat only primes
    send_counts(32'h80000000, 32'h7FFFFFFF);   // standing still
    send_counts(32'h80000100, 32'h80000100);
    send_counts(32'h00000100, 32'h00000100);   // largest backward jump
    send_counts(32'h80000100, 32'h80000100);   // largest backward jump again
    send_counts(32'h80000100, 32'h00000100);   // left wheel only, right wheel still
    send_counts(32'h00000000, 32'h80000000);
    send_counts(32'hFFFFFFFF, 32'h00000000);
    send_counts(32'h7FFFFFFF, 32'hFFFFFFFF);
    send_counts(32'h7FFFFFFE, 32'hFFFFFFFF);
    send_counts(32'h7FFFFFFF, 32'hFFFFFFFE);
    send_counts(32'h7FFFFFFF, 32'hFFFFFFFE);
    for (int i = 0; i < 8; i++) send_counts($urandom, $urandom);
  endtask

  task automatic test_register_extremes();
    write_reg(ddo_pkg::CfgMpt, 32'hFFFFFFFF);
    write_reg(ddo_pkg::CfgTpt, 32'h00000001);
    // Huge jumps at full scale drive the position into saturation.
    for (int i = 0; i < 6; i++)
      send_counts(last_r + 32'h7FFFFFFF, last_l + 32'h7FFFFFFF);
    for (int i = 0; i < 6; i++)
      send_counts(last_r - 32'h80000000, last_l + 32'h7FFFFFFF);
    write_reg(ddo_pkg::CfgMpt, 32'h00000001);
    write_reg(ddo_pkg::CfgTpt, 32'hFFFFFFFF);
    for (int i = 0; i < 6; i++) send_counts($urandom, $urandom);
    write_reg(ddo_pkg::CfgMpt, 32'h00000000);   // a zero scale means no travel
    write_reg(ddo_pkg::CfgTpt, 32'h00000000);   // and no turning
    for (int i = 0; i < 4; i++) send_counts($urandom, $urandom);
  endtask

  task automatic test_random_drive(int n);
    logic [31:0] vr, vl, base;
    for (int i = 0; i < n; i++) begin
      if (i % 250 == 0) begin
        write_reg(ddo_pkg::CfgMpt,
                  $urandom_range(7) == 0 ? $urandom : $urandom_range(1, 3000000));
        write_reg(ddo_pkg::CfgTpt,
                  $urandom_range(7) == 0 ? $urandom : $urandom_range(1, 4000000));
      end
      calm = (i >= 300 && i < 450);
      if ($urandom_range(99) < 85) begin
        base = $urandom_range(3000);
        vr = last_r + base + $urandom_range(400) - 200;
        vl = last_l + base + $urandom_range(400) - 200;
        if ($urandom_range(1)) begin
          vr = last_r - base;
          vl = last_l - base + $urandom_range(100);
        end
      end else begin
        vr = $urandom;
        vl = $urandom;
      end
      send_counts(vr, vl);
    end
    calm = 0;
  endtask

  task automatic test_backpressure();
    hold_req = 800;
    calm = 1;
    for (int i = 0; i < 6; i++)
      send_counts(last_r + $urandom_range(500), last_l + $urandom_range(500));
    calm = 0;
    // Sender pause until the pipeline has emptied.
    in_valid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    for (int i = 0; i < 6; i++)
      send_counts(last_r + $urandom_range(500), last_l - $urandom_range(500));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random_drive(1000);
    wait_idle();
    if (errors == 0) begin
      $display("diff_drive_odometry_unit test passed");
    end else begin
      $display("diff_drive_odometry_unit test failed");
    end
    $finish;
  end

endmodule
